/* src/plet_pkg.sv */
`timescale 1ns / 1ps

package plet_pkg;

    // Field widths fixed by the item format
    localparam int LABEL_W = 11;
    localparam int VALUE_W = 32;

    typedef logic [LABEL_W-1:0]        label_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    // Beat opcode
    typedef enum logic {
        MODE_ACCUM = 1'b0,
        MODE_READ  = 1'b1
    } mode_t;

    // Tracking direction
    typedef enum logic {
        DIR_MAX = 1'b0,
        DIR_MIN = 1'b1
    } dir_t;

    // Fill values: smallest positive Q16.16 step, largest Q16.16 value
    localparam value_t FILL_MAX = 32'sh0000_0001;
    localparam value_t FILL_MIN = 32'sh7FFF_FFFF;

    function automatic value_t fill_of(input dir_t dir);
        value_t f;
        f = (dir == DIR_MIN) ? FILL_MIN : FILL_MAX;
        return f;
    endfunction

endpackage

/* src/per_label_extremum_tracker_core.sv */
`timescale 1ns / 1ps
// Channel | handshake              | payload
// --------+------------------------+--------------------------------------
// input   | in_valid / in_stall    | mode, pixel_value, label
// output  | out_valid / out_stall  | read_label, extremum_value
// config  | cfg_we                 | cfg_wdata (direction)
//
// One beat per cycle while in_stall is low: read at accept, modify and write
// back from the stage 2 registers through the table RAM's single write port;
// back-to-back beats on the same label are forwarded from the last write.
// After reset and after every direction write the table is refilled, one
// entry per cycle over the whole table; in_stall stays high during that pass.
// A read beat waiting on a stalled output register holds the pipeline.

module per_label_extremum_tracker_core #(
    parameter int MAX_LABELS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic signed [31:0]    pixel_value,
    input  logic [10:0]           label,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [10:0]           read_label,
    output logic signed [31:0]    extremum_value,
    // configuration
    input  logic                  cfg_we,
    input  logic                  cfg_wdata
);

    localparam int ADDR_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int IDX_W  = 17;

    // Direction register
    plet_pkg::dir_t dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= plet_pkg::DIR_MAX;
        end
        else if (cfg_we)
        begin
            dir_reg <= plet_pkg::dir_t'(cfg_wdata);
        end
    end

    // Refill sweep
    logic              clr_active;
    logic [ADDR_W-1:0] clr_addr;

    plet_clear #(
        .DEPTH (MAX_LABELS),
        .ADDR_W(ADDR_W)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_we),
        .active(clr_active),
        .addr  (clr_addr)
    );

    // Label decode: label 0 and labels past the table are dropped
    logic [IDX_W-1:0]  lbl_ext;
    logic [IDX_W-1:0]  idx_full;
    logic              lbl_ok;
    logic [ADDR_W-1:0] in_addr;
    logic              in_accept;

    assign lbl_ext   = IDX_W'(label);
    assign idx_full  = lbl_ext - IDX_W'(1);
    assign lbl_ok    = (label != '0) && (lbl_ext <= IDX_W'(MAX_LABELS));
    assign in_addr   = idx_full[ADDR_W-1:0];
    assign in_accept = in_valid && !in_stall;

    // Stage 2 registers (modify / write back)
    logic                   s2_valid_reg;
    plet_pkg::mode_t        s2_mode_reg;
    plet_pkg::value_t       s2_val_reg;
    plet_pkg::label_t       s2_label_reg;
    logic [ADDR_W-1:0]      s2_addr_reg;

    // Forward of the last table write
    logic                   fwd_valid_reg;
    logic [ADDR_W-1:0]      fwd_addr_reg;
    plet_pkg::value_t       fwd_data_reg;

    // Output register
    logic                   out_valid_reg;
    plet_pkg::label_t       out_label_reg;
    plet_pkg::value_t       out_value_reg;

    logic                   s2_is_read;
    logic                   s2_adv;
    logic                   out_load;

    assign s2_is_read = (s2_mode_reg == plet_pkg::MODE_READ);
    assign s2_adv     = !s2_is_read || !out_valid_reg || !out_stall;
    assign out_load   = s2_valid_reg && s2_is_read && s2_adv;
    assign in_stall   = clr_active || (s2_valid_reg && !s2_adv);

    // Table RAM
    logic [31:0]       ram_rdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;

    plet_ram #(
        .WIDTH (32),
        .DEPTH (MAX_LABELS),
        .ADDR_W(ADDR_W)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (in_accept),
        .raddr(in_addr),
        .rdata(ram_rdata)
    );

    // Modify: pick current entry, compare, choose write-back
    plet_pkg::value_t cur;
    logic             replace;
    logic             s2_we;
    plet_pkg::value_t s2_wdata;

    always_comb
    begin
        cur = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg))
            ? fwd_data_reg : plet_pkg::value_t'(ram_rdata);
        if (dir_reg == plet_pkg::DIR_MAX)
        begin
            replace = s2_val_reg > cur;
        end
        else
        begin
            replace = s2_val_reg < cur;
        end
        if (s2_is_read)
        begin
            s2_we    = s2_valid_reg && s2_adv;
            s2_wdata = plet_pkg::fill_of(dir_reg);
        end
        else
        begin
            s2_we    = s2_valid_reg && replace;
            s2_wdata = s2_val_reg;
        end
    end

    // Write port: the refill sweep owns it while active
    always_comb
    begin
        if (clr_active)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr;
            ram_wdata = plet_pkg::fill_of(dir_reg);
        end
        else
        begin
            ram_we    = s2_we;
            ram_waddr = s2_addr_reg;
            ram_wdata = s2_wdata;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s2_valid_reg <= lbl_ok;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (clr_active)
            begin
                fwd_valid_reg <= 1'b0;
            end
            else if (s2_we)
            begin
                fwd_valid_reg <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_mode_reg  <= plet_pkg::mode_t'(mode);
            s2_val_reg   <= pixel_value;
            s2_label_reg <= label;
            s2_addr_reg  <= in_addr;
        end
        if (!clr_active && s2_we)
        begin
            fwd_addr_reg <= s2_addr_reg;
            fwd_data_reg <= s2_wdata;
        end
        if (out_load)
        begin
            out_label_reg <= s2_label_reg;
            out_value_reg <= cur;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_label     = out_label_reg;
    assign extremum_value = out_value_reg;

    // Assertions
    a_read_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("read beat left stage 2 without loading the output");

    a_hold_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |=> $stable(ram_rdata))
        else $error("table read data changed under a held beat");

    a_sweep_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (clr_active && !cfg_we && (clr_addr != ADDR_W'(MAX_LABELS - 1)))
        |=> clr_active)
        else $error("refill sweep stopped early");

endmodule

/* src/plet_ram.sv */
`timescale 1ns / 1ps

module plet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (read-first)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/plet_clear.sv */
`timescale 1ns / 1ps

module plet_clear #(
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              active,
    output logic [ADDR_W-1:0] addr
);

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

    logic              active_reg, active_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;

    // Sweep one entry per cycle; restart on every direction write
    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
        else if (active_reg)
        begin
            if (cnt_reg == LAST)
            begin
                active_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign active = active_reg;
    assign addr   = cnt_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_LABELS  = 1024;
    localparam int STALL_LIMIT = 6000;   // refill pass plus long random stalls
    localparam int PHASE_BEATS = 140;    // labeled beats per random phase
    localparam int SETTLE      = 4;      // read-modify-write depth, with margin
    localparam int MAX_REPORTS = 10;

    // Short names for the script table
    localparam plet_pkg::mode_t MODE_READ  = plet_pkg::MODE_READ;
    localparam plet_pkg::mode_t MODE_ACCUM = plet_pkg::MODE_ACCUM;
    localparam plet_pkg::dir_t  DIR_MAX    = plet_pkg::DIR_MAX;
    localparam plet_pkg::dir_t  DIR_MIN    = plet_pkg::DIR_MIN;

    // One labeled read result
    typedef struct packed {
        plet_pkg::label_t lbl;
        plet_pkg::value_t val;
    } read_rec_t;

    typedef enum logic {
        ROW_BEAT = 1'b0,
        ROW_DIR  = 1'b1
    } row_kind_t;

    // Directed script row: a beat, or a direction write
    typedef struct packed {
        row_kind_t        kind;
        plet_pkg::mode_t  op;
        plet_pkg::label_t lbl;
        logic [31:0]      val;
        plet_pkg::dir_t   dir;
        logic             typed;
        logic [31:0]      want;
    } script_row_t;

    localparam int N_ROWS = 27;

    script_row_t script [N_ROWS] = '{
        // fresh table after reset holds the maximum fill
        '{ROW_BEAT, MODE_READ,  11'd1,    32'h0,        DIR_MAX, 1'b1, 32'h0000_0001},
        '{ROW_BEAT, MODE_ACCUM, 11'd1,    32'h7FFF_FFFF, DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd1,    32'h0,        DIR_MAX, 1'b1, 32'h7FFF_FFFF},
        // read puts the entry back to fill
        '{ROW_BEAT, MODE_READ,  11'd1,    32'h0,        DIR_MAX, 1'b1, 32'h0000_0001},
        '{ROW_BEAT, MODE_ACCUM, 11'd1024, 32'h8000_0000, DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd1024, 32'h0,        DIR_MAX, 1'b1, 32'h0000_0001},
        // unlabeled and out-of-range beats are dropped
        '{ROW_BEAT, MODE_ACCUM, 11'd0,    32'h0000_0005, DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd0,    32'h0,        DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_ACCUM, 11'd1025, 32'h0004_0000, DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd2047, 32'h0,        DIR_MAX, 1'b0, 32'h0},
        // equal value does not replace
        '{ROW_BEAT, MODE_ACCUM, 11'd5,    32'h0000_0001, DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd5,    32'h0,        DIR_MAX, 1'b0, 32'h0},
        // back-to-back on one label
        '{ROW_BEAT, MODE_ACCUM, 11'd7,    32'h0000_0002, DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_ACCUM, 11'd7,    32'h0000_0002, DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_ACCUM, 11'd7,    32'hFFFF_FFFF, DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd7,    32'h0,        DIR_MAX, 1'b0, 32'h0},
        // minimum direction
        '{ROW_DIR,  MODE_ACCUM, 11'd0,    32'h0,        DIR_MIN, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd3,    32'h0,        DIR_MAX, 1'b1, 32'h7FFF_FFFF},
        '{ROW_BEAT, MODE_ACCUM, 11'd3,    32'h8000_0000, DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd3,    32'h0,        DIR_MAX, 1'b1, 32'h8000_0000},
        '{ROW_BEAT, MODE_ACCUM, 11'd3,    32'h7FFF_FFFF, DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd3,    32'h0,        DIR_MAX, 1'b0, 32'h0},
        // rewriting the same direction still refills
        '{ROW_BEAT, MODE_ACCUM, 11'd9,    32'h0000_0064, DIR_MAX, 1'b0, 32'h0},
        '{ROW_DIR,  MODE_ACCUM, 11'd0,    32'h0,        DIR_MIN, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd9,    32'h0,        DIR_MAX, 1'b1, 32'h7FFF_FFFF},
        // back to maximum
        '{ROW_DIR,  MODE_ACCUM, 11'd0,    32'h0,        DIR_MAX, 1'b0, 32'h0},
        '{ROW_BEAT, MODE_READ,  11'd2,    32'h0,        DIR_MAX, 1'b1, 32'h0000_0001}
    };

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             mode;
    plet_pkg::value_t pixel_value;
    plet_pkg::label_t label;
    logic             out_valid;
    logic             out_stall;
    plet_pkg::label_t read_label;
    plet_pkg::value_t extremum_value;
    logic             cfg_we;
    logic             cfg_wdata;

    // Shadow of the block state
    plet_pkg::value_t extrema [MAX_LABELS];
    plet_pkg::dir_t   track_dir;
    plet_pkg::value_t fill_now;
    read_rec_t        pending_reads [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int mismatches;
    int quiet_cycles;

    per_label_extremum_tracker_core #(
        .MAX_LABELS (MAX_LABELS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .pixel_value    (pixel_value),
        .label          (label),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_label     (read_label),
        .extremum_value (extremum_value),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Shadow table refill on a direction change
    task automatic refill_extrema(input plet_pkg::dir_t d);
        track_dir = d;
        fill_now  = (d == plet_pkg::DIR_MIN) ? plet_pkg::FILL_MIN : plet_pkg::FILL_MAX;
        for (int i = 0; i < MAX_LABELS; i++)
            extrema[i] = fill_now;
    endtask

    // Apply one beat to the shadow table; a labeled read yields a result
    task automatic update_extrema(input plet_pkg::mode_t op,
                                  input plet_pkg::value_t v,
                                  input plet_pkg::label_t l,
                                  output bit hit, output read_rec_t rec);
        int idx;
        hit = 1'b0;
        rec = '0;
        if (l == 0 || l > MAX_LABELS)
            return;
        idx = int'(l) - 1;
        if (op == plet_pkg::MODE_ACCUM)
        begin
            if (track_dir == plet_pkg::DIR_MAX ? (v > extrema[idx]) : (v < extrema[idx]))
                extrema[idx] = v;
        end
        else
        begin
            hit         = 1'b1;
            rec.lbl     = l;
            rec.val     = extrema[idx];
            extrema[idx] = fill_now;
        end
    endtask

    // Present one beat, wait for accept, record what it should return
    task automatic send_beat(input plet_pkg::mode_t op, input plet_pkg::value_t v,
                             input plet_pkg::label_t l,
                             input bit typed, input plet_pkg::value_t want);
        int        gap;
        bit        hit;
        read_rec_t rec;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        pixel_value <= v;
        label       <= l;
        do
            @(posedge clk);
        while (in_stall);
        update_extrema(op, v, l, hit, rec);
        if (hit)
        begin
            if (typed)
                rec.val = want;
            pending_reads.push_back(rec);
        end
    endtask

    // Direction write, only with the block drained
    task automatic write_direction(input plet_pkg::dir_t d);
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        refill_extrema(d);
    endtask

    task automatic note_mismatch(input string what, input read_rec_t exp_rec);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected label %0d value %h, got label %0d value %h",
                     $realtime, what, exp_rec.lbl, exp_rec.val, read_label, extremum_value);
    endtask

    // Receiver stall pattern
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_idle_pct);

    // Result checker and watchdog
    always @(posedge clk)
    begin
        read_rec_t exp_rec;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_reads.size() == 0)
                begin
                    exp_rec = '0;
                    note_mismatch("result with no read pending", exp_rec);
                end
                else
                begin
                    exp_rec = pending_reads.pop_front();
                    if (read_label !== exp_rec.lbl || extremum_value !== exp_rec.val)
                        note_mismatch("read mismatch", exp_rec);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : main
        int               counted;
        int               pick;
        plet_pkg::mode_t  op;
        plet_pkg::value_t v;
        plet_pkg::label_t l;
        plet_pkg::dir_t   d;

        tx_idle_pct  = 21;
        rx_idle_pct  = 63;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= plet_pkg::MODE_ACCUM;
        pixel_value <= '0;
        label       <= '0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= plet_pkg::DIR_MAX;
        refill_extrema(plet_pkg::DIR_MAX);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed script
        for (int r = 0; r < N_ROWS; r++)
        begin
            if (script[r].kind == ROW_DIR)
                write_direction(script[r].dir);
            else
                send_beat(script[r].op, script[r].val, script[r].lbl,
                          script[r].typed, script[r].want);
        end

        // Random phases, each with its own idle pattern and direction
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 63 : 0;
            rx_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 21 : 0;
            d = (ph == 0) ? plet_pkg::DIR_MIN : (ph == 1) ? plet_pkg::DIR_MAX
                : (($urandom_range(1) == 1) ? plet_pkg::DIR_MIN : plet_pkg::DIR_MAX);
            write_direction(d);
            counted = 0;
            while (counted < PHASE_BEATS)
            begin
                op = ($urandom_range(99) < 30) ? plet_pkg::MODE_READ : plet_pkg::MODE_ACCUM;
                // values: extremes, fills, near zero, anything
                case ($urandom_range(9))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = plet_pkg::FILL_MAX;
                    3:       v = plet_pkg::value_t'($urandom_range(64)) - 32;
                    default: v = plet_pkg::value_t'($urandom);
                endcase
                // labels: mostly a small hot set so entries build up
                pick = $urandom_range(99);
                if (pick < 45)
                    l = plet_pkg::label_t'($urandom_range(8, 1));
                else if (pick < 80)
                    l = plet_pkg::label_t'($urandom_range(MAX_LABELS, 1));
                else if (pick < 85)
                    l = plet_pkg::label_t'(MAX_LABELS);
                else if (pick < 92)
                    l = '0;
                else
                    l = plet_pkg::label_t'($urandom_range(2047, MAX_LABELS + 1));
                send_beat(op, v, l, 1'b0, '0);
                if (l != 0 && l <= MAX_LABELS)
                    counted++;
            end
        end

        // Drain
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE * 2) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
